// File: rtl/core/mcr_pkg.sv
`timescale 1ns / 1ps
package mcr_pkg;

  localparam int DEC_BITS    = 18;
  localparam int COORD_W     = 16;
  localparam int RADIUS_W    = 12;
  localparam int SPAN_W      = 13;
  localparam int COLOR_W     = 32;
  localparam int SET_IDX_W   = 3;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam logic signed [DEC_BITS-1:0] DEC_INIT         = 18'sd3;
  localparam logic signed [DEC_BITS-1:0] DEC_INC_DIAG     = 18'sd10;
  localparam logic signed [DEC_BITS-1:0] DEC_INC_STRAIGHT = 18'sd6;

  localparam logic [SPAN_W-1:0]    SPAN_MAX         = 13'h1FFF;
  localparam logic [SPAN_W-1:0]    SPAN_ONE         = 13'd1;
  localparam logic [SET_IDX_W-1:0] SET_LAST_OUTLINE = 3'd7;
  localparam logic [SET_IDX_W-1:0] SET_LAST_FILL    = 3'd3;

  typedef struct packed {
    logic                      opcode;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [RADIUS_W-1:0]       radius;
    logic                      fill_mode;
    logic [COLOR_W-1:0]        color;
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic [SPAN_W-1:0]         span_length;
    logic                      is_span;
    logic [COLOR_W-1:0]        pixel_color;
    logic                      last_of_run;
    logic                      circle_done;
  } result_t;

  // one set of results: centre and octant offsets, all sign-extended to 16 bits
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] a;
    logic signed [COORD_W-1:0] b;
    logic                      fill;
    logic [COLOR_W-1:0]        color;
    logic                      done;
  } set_t;

endpackage

// File: rtl/core/mcr_front.sv
`timescale 1ns / 1ps
module mcr_front #(
  parameter int RADIUS_BITS = 12,
  parameter int COORD_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  mcr_pkg::cmd_t    cmd,
  output logic             q_push,
  output mcr_pkg::set_t    q_data,
  input  logic             q_full
);

  localparam int OFF_BITS = RADIUS_BITS + 2;
  localparam int R_TAKE   = (RADIUS_BITS < mcr_pkg::RADIUS_W) ? RADIUS_BITS : mcr_pkg::RADIUS_W;

  logic signed [mcr_pkg::COORD_W-1:0]  center_col, center_col_next;
  logic signed [mcr_pkg::COORD_W-1:0]  center_row, center_row_next;
  logic signed [OFF_BITS-1:0]          offset_x, offset_x_next;
  logic signed [OFF_BITS-1:0]          offset_y, offset_y_next;
  logic signed [mcr_pkg::DEC_BITS-1:0] decision, decision_next;
  logic                                fill_flag, fill_flag_next;
  logic [mcr_pkg::COLOR_W-1:0]         draw_color, draw_color_next;
  logic                                active, active_next;

  logic                                accept;
  logic                                is_start;
  logic                                done;
  logic signed [OFF_BITS-1:0]          r_ext;
  logic signed [OFF_BITS-1:0]          step_x, step_y;
  logic signed [mcr_pkg::DEC_BITS-1:0] diff;

  assign full = q_full;

  always_comb begin
    accept          = push && !q_full;
    is_start        = cmd.opcode == mcr_pkg::OP_START;
    r_ext           = OFF_BITS'(cmd.radius[R_TAKE-1:0]);
    step_x          = offset_x + OFF_BITS'(1);
    step_y          = offset_y;
    diff            = '0;
    center_col_next = center_col;
    center_row_next = center_row;
    offset_x_next   = offset_x;
    offset_y_next   = offset_y;
    decision_next   = decision;
    fill_flag_next  = fill_flag;
    draw_color_next = draw_color;
    active_next     = active;
    done            = 1'b0;
    if (is_start) begin
      center_col_next = mcr_pkg::COORD_W'($signed(cmd.center_x[COORD_BITS-1:0]));
      center_row_next = mcr_pkg::COORD_W'($signed(cmd.center_y[COORD_BITS-1:0]));
      offset_x_next   = '0;
      offset_y_next   = r_ext;
      decision_next   = mcr_pkg::DEC_INIT - (mcr_pkg::DEC_BITS'(r_ext) <<< 1);
      fill_flag_next  = cmd.fill_mode;
      draw_color_next = cmd.color;
      active_next     = 1'b1;
    end else begin
      if (decision > 0) begin
        step_y        = offset_y - OFF_BITS'(1);
        diff          = mcr_pkg::DEC_BITS'(step_x) - mcr_pkg::DEC_BITS'(step_y);
        decision_next = decision + (diff <<< 2) + mcr_pkg::DEC_INC_DIAG;
      end else begin
        decision_next = decision + (mcr_pkg::DEC_BITS'(step_x) <<< 2)
                        + mcr_pkg::DEC_INC_STRAIGHT;
      end
      offset_x_next = step_x;
      offset_y_next = step_y;
      done          = step_y < step_x;
      active_next   = !done;
    end
  end

  assign q_push = accept && (is_start || active);

  always_comb begin
    q_data.cx    = center_col_next;
    q_data.cy    = center_row_next;
    q_data.a     = mcr_pkg::COORD_W'(offset_x_next);
    q_data.b     = mcr_pkg::COORD_W'(offset_y_next);
    q_data.fill  = fill_flag_next;
    q_data.color = draw_color_next;
    q_data.done  = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_col <= '0;
      center_row <= '0;
      offset_x   <= '0;
      offset_y   <= '0;
      decision   <= '0;
      fill_flag  <= 1'b0;
      draw_color <= '0;
      active     <= 1'b0;
    end else if (q_push) begin
      center_col <= center_col_next;
      center_row <= center_row_next;
      offset_x   <= offset_x_next;
      offset_y   <= offset_y_next;
      decision   <= decision_next;
      fill_flag  <= fill_flag_next;
      draw_color <= draw_color_next;
      active     <= active_next;
    end
  end

endmodule

// File: rtl/core/mcr_queue.sv
`timescale 1ns / 1ps
module mcr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  mcr_pkg::set_t wr_data,
  output logic          full,
  input  logic          rd,
  output mcr_pkg::set_t rd_data,
  output logic          empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  mcr_pkg::set_t      slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;
  logic               do_wr;
  logic               do_rd;

  assign full    = count == (PTR_W + 1)'(DEPTH);
  assign empty   = count == '0;
  assign rd_data = slots[rd_ptr];
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

endmodule

// File: rtl/core/mcr_back.sv
`timescale 1ns / 1ps
module mcr_back #(
  parameter int COORD_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  mcr_pkg::set_t    set_in,
  input  logic             set_empty,
  output logic             set_pop,
  output logic             empty,
  input  logic             pop,
  output mcr_pkg::result_t result
);

  logic                                out_valid;
  mcr_pkg::result_t                    out_item;
  mcr_pkg::result_t                    gen;
  logic [mcr_pkg::SET_IDX_W-1:0]       idx;
  logic [mcr_pkg::SET_IDX_W-1:0]       last_idx;
  logic                                load;
  logic                                is_last;
  logic                                swap;
  logic signed [mcr_pkg::COORD_W-1:0]  p, q;
  logic signed [mcr_pkg::COORD_W-1:0]  xs, ys;
  logic [mcr_pkg::COORD_W:0]           twice;

  always_comb begin
    last_idx = set_in.fill ? mcr_pkg::SET_LAST_FILL : mcr_pkg::SET_LAST_OUTLINE;
    is_last  = idx == last_idx;
    swap     = set_in.fill ? idx[1] : idx[2];
    p        = swap ? set_in.b : set_in.a;
    q        = swap ? set_in.a : set_in.b;
    twice    = {p, 1'b0};
    if (set_in.fill) begin
      xs = set_in.cx - p;
      ys = idx[0] ? set_in.cy - q : set_in.cy + q;
      if (p[mcr_pkg::COORD_W-1]) begin
        gen.span_length = '0;
      end else if (twice > (mcr_pkg::COORD_W + 1)'(mcr_pkg::SPAN_MAX)) begin
        gen.span_length = mcr_pkg::SPAN_MAX;
      end else begin
        gen.span_length = twice[mcr_pkg::SPAN_W-1:0];
      end
    end else begin
      xs = set_in.cx + (idx[0] ? ~p : p);
      ys = set_in.cy + (idx[1] ? ~q : q);
      gen.span_length = mcr_pkg::SPAN_ONE;
    end
    gen.pixel_x     = mcr_pkg::COORD_W'($signed(xs[COORD_BITS-1:0]));
    gen.pixel_y     = mcr_pkg::COORD_W'($signed(ys[COORD_BITS-1:0]));
    gen.is_span     = set_in.fill;
    gen.pixel_color = set_in.color;
    gen.last_of_run = is_last;
    gen.circle_done = is_last && set_in.done;
  end

  assign load    = !out_valid || pop;
  assign set_pop = load && !set_empty && is_last;
  assign empty   = !out_valid;
  assign result  = out_item;

  always_ff @(posedge clk) begin
    if (load && !set_empty) begin
      out_item <= gen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !set_empty;
      if (!set_empty) begin
        idx <= is_last ? '0 : idx + mcr_pkg::SET_IDX_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/midpoint_circle_rasterizer_top.sv
`timescale 1ns / 1ps
// midpoint circle rasterizer
// command channel: cmd is taken when push is high and full is low. a start
// command latches centre, radius, mode and colour and yields the first set; an
// advance command runs one step of the circle and yields the next set; an
// advance with no circle in progress yields nothing.
// result channel: the oldest item sits on result while empty is low and is
// taken when pop is high. outline sets are eight pixels, fill sets four spans;
// last_of_run marks the end of a set, circle_done the end of the circle.
// with the back end idle, the first item of a set is written into the queue and
// then into the output register before it is on result.
// throughput: one result item per cycle from the single output register while pop
// stays high, so an outline command yields eight items and a fill command four;
// the front end takes a command per cycle while the two-set queue has room.
// reset clears the circle state, the queue pointers and the output valid flag.
// if pop stays low the result holds, the queue fills and full is raised.
module midpoint_circle_rasterizer_top #(
  parameter int RADIUS_BITS = 12,
  parameter int COORD_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  mcr_pkg::cmd_t    cmd,
  output logic             empty,
  input  logic             pop,
  output mcr_pkg::result_t result
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  mcr_pkg::set_t q_wr_data;
  mcr_pkg::set_t q_rd_data;

  mcr_front #(
    .RADIUS_BITS(RADIUS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .cmd    (cmd),
    .q_push (q_push),
    .q_data (q_wr_data),
    .q_full (q_full)
  );

  mcr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  mcr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .set_in    (q_rd_data),
    .set_empty (q_empty),
    .set_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// File: rtl/core/mcr_checker.sv
`timescale 1ns / 1ps
module mcr_checker (
  input logic             clk,
  input logic             rst,
  input logic             push,
  input logic             full,
  input mcr_pkg::cmd_t    cmd,
  input logic             empty,
  input logic             pop,
  input mcr_pkg::result_t result
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.circle_done) |-> result.last_of_run)
    else $error("circle end not on last item of a set");

  a_pixel_length: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.is_span) |-> (result.span_length == mcr_pkg::SPAN_ONE))
    else $error("outline pixel with length other than one");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed while stalled");

endmodule

bind midpoint_circle_rasterizer_top mcr_checker u_mcr_checker (.*);

// File: tb/tb_midpoint_circle_rasterizer_top.sv
`timescale 1ns / 1ps
module tb_midpoint_circle_rasterizer_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 190;
  localparam int DRAIN_WAIT  = 20;

  typedef struct packed {
    mcr_pkg::cmd_t    c;
    int               n;
    logic             chk;
    mcr_pkg::result_t first;
  } step_row_t;

  logic             clk;
  logic             rst;
  logic             push;
  logic             full;
  mcr_pkg::cmd_t    cmd;
  logic             empty;
  logic             pop;
  mcr_pkg::result_t result;

  midpoint_circle_rasterizer_top dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .cmd    (cmd),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // predictor state
  logic signed [mcr_pkg::COORD_W-1:0]  ctr_col;
  logic signed [mcr_pkg::COORD_W-1:0]  ctr_row;
  logic signed [12:0]                  off_x;
  logic signed [12:0]                  off_y;
  logic signed [mcr_pkg::DEC_BITS-1:0] dec;
  logic                                fill_on;
  logic [mcr_pkg::COLOR_W-1:0]         ink;
  bit                                  running;

  mcr_pkg::result_t px_set [8];
  int               px_n;
  mcr_pkg::result_t pending_px [$];

  bit               row_typed;
  int               row_n;
  logic             row_chk;
  mcr_pkg::result_t row_first;

  int send_idle;
  int pop_stall;
  int errs;
  int cycles;
  int items_sent;
  int circles_done;
  int pixels_seen;
  int spans_seen;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic mcr_pkg::cmd_t mk_cmd(input logic op, input logic [15:0] cx,
                                           input logic [15:0] cy, input logic [11:0] r,
                                           input logic fl, input logic [31:0] col);
    mcr_pkg::cmd_t c;
    c.opcode    = op;
    c.center_x  = cx;
    c.center_y  = cy;
    c.radius    = r;
    c.fill_mode = fl;
    c.color     = col;
    return c;
  endfunction

  function automatic mcr_pkg::result_t mk_res(input logic [15:0] x, input logic [15:0] y,
                                              input logic [12:0] len, input logic sp,
                                              input logic [31:0] col);
    mcr_pkg::result_t r;
    r.pixel_x     = x;
    r.pixel_y     = y;
    r.span_length = len;
    r.is_span     = sp;
    r.pixel_color = col;
    r.last_of_run = 1'b0;
    r.circle_done = 1'b0;
    return r;
  endfunction

  task automatic add_px(input int x, input int y, input int len, input logic sp);
    int l;
    l = len;
    if (l < 0) l = 0;
    if (l > 8191) l = 8191;
    px_set[px_n] = mk_res(16'(x), 16'(y), 13'(l), sp, ink);
    px_n++;
  endtask

  task automatic rasterise_cmd(input mcr_pkg::cmd_t c);
    int r;
    int a;
    int b;
    int dd;
    int cx;
    int cy;
    bit done;
    px_n = 0;
    done = 0;
    if (c.opcode == mcr_pkg::OP_START) begin
      r = c.radius;
      ctr_col = c.center_x;
      ctr_row = c.center_y;
      fill_on = c.fill_mode;
      ink = c.color;
      off_x = '0;
      off_y = 13'(r);
      dec = 18'(3 - 2 * r);
      running = 1;
    end else begin
      if (!running) return;
      a = int'(off_x) + 1;
      b = off_y;
      if (dec > 0) begin
        b = b - 1;
        dd = int'(dec) + 4 * (a - b) + 10;
      end else begin
        dd = int'(dec) + 4 * a + 6;
      end
      off_x = 13'(a);
      off_y = 13'(b);
      dec = 18'(dd);
      if (b < a) begin
        done = 1;
        running = 0;
      end
    end
    cx = ctr_col;
    cy = ctr_row;
    a = off_x;
    b = off_y;
    if (!fill_on) begin
      add_px(cx + a, cy + b, 1, 1'b0);
      add_px(cx - a - 1, cy + b, 1, 1'b0);
      add_px(cx + a, cy - b - 1, 1, 1'b0);
      add_px(cx - a - 1, cy - b - 1, 1, 1'b0);
      add_px(cx + b, cy + a, 1, 1'b0);
      add_px(cx - b - 1, cy + a, 1, 1'b0);
      add_px(cx + b, cy - a - 1, 1, 1'b0);
      add_px(cx - b - 1, cy - a - 1, 1, 1'b0);
    end else begin
      add_px(cx - a, cy + b, 2 * a, 1'b1);
      add_px(cx - a, cy - b, 2 * a, 1'b1);
      add_px(cx - b, cy + a, 2 * b, 1'b1);
      add_px(cx - b, cy - a, 2 * b, 1'b1);
    end
    px_set[px_n-1].last_of_run = 1'b1;
    px_set[px_n-1].circle_done = done;
  endtask

  task automatic cmp_field(input string nm, input longint e, input longint g);
    if (e != g) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, e, g);
      errs++;
    end
  endtask

  task automatic check_px(input mcr_pkg::result_t got);
    mcr_pkg::result_t e;
    if (pending_px.size() == 0) begin
      $display("%0t: unexpected item, expected none, got %p", $time, got);
      errs++;
      return;
    end
    e = pending_px.pop_front();
    cmp_field("pixel_x", e.pixel_x, got.pixel_x);
    cmp_field("pixel_y", e.pixel_y, got.pixel_y);
    cmp_field("span_length", e.span_length, got.span_length);
    cmp_field("is_span", e.is_span, got.is_span);
    cmp_field("pixel_color", e.pixel_color, got.pixel_color);
    cmp_field("last_of_run", e.last_of_run, got.last_of_run);
    cmp_field("circle_done", e.circle_done, got.circle_done);
    if (got.circle_done === 1'b1) circles_done++;
    if (got.is_span === 1'b1) spans_seen++;
    else pixels_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) check_px(result);
      if (push && !full) begin
        rasterise_cmd(cmd);
        if (row_typed) begin
          if (row_n != px_n) begin
            $display("%0t: item count mismatch, expected %0d, got %0d", $time, row_n, px_n);
            errs++;
          end
          if (row_chk && px_n > 0) px_set[0] = row_first;
        end
        for (int i = 0; i < px_n; i++) pending_px.insert(pending_px.size(), px_set[i]);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) pop = 1'b0;
    else pop = ($urandom_range(0, 99) >= pop_stall);
  end

  task automatic send_cmd(input mcr_pkg::cmd_t c);
    bool_idle: while ($urandom_range(0, 99) < send_idle) begin
      push = 1'b0;
      @(negedge clk);
    end
    if (!(c.opcode == mcr_pkg::OP_ADVANCE && !running)) items_sent++;
    push = 1'b1;
    cmd = c;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_advance();
    send_cmd(mk_cmd(mcr_pkg::OP_ADVANCE, 16'($urandom), 16'($urandom), 12'($urandom),
                    1'($urandom), $urandom));
  endtask

  // mostly whole circles, some abandoned early, the odd idle advance
  task automatic rand_circle();
    mcr_pkg::cmd_t c;
    int   steps;
    bit   big;
    big = ($urandom_range(0, 7) == 0);
    c = mk_cmd(mcr_pkg::OP_START, 16'($urandom), 16'($urandom),
               big ? 12'($urandom_range(0, 4095)) : 12'($urandom_range(0, 24)),
               1'($urandom), $urandom);
    send_cmd(c);
    if (big || $urandom_range(0, 3) == 0) steps = $urandom_range(0, 12);
    else steps = 1 << 20;
    while (running && steps > 0) begin
      send_advance();
      steps--;
    end
    if ($urandom_range(0, 2) == 0) send_advance();
  endtask

  initial begin
    step_row_t rows [$];
    step_row_t row;
    int goal;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    cmd = '0;
    send_idle = 0;
    pop_stall = 0;
    row_typed = 0;
    row_n = 0;
    row_chk = 0;
    row_first = '0;

    rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_ADVANCE, 16'h0, 16'h0, 12'd0, 1'b0, 32'h0),
                               0, 1'b0, '0});
    rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_START, 16'h0, 16'h0, 12'd0, 1'b0,
                                      32'hFFFFFFFF), 8, 1'b1,
                               mk_res(16'h0000, 16'h0000, mcr_pkg::SPAN_ONE, 1'b0,
                                      32'hFFFFFFFF)});
    rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_ADVANCE, 16'hFFFF, 16'hFFFF, 12'hFFF, 1'b1,
                                      32'hFFFFFFFF), 8, 1'b0, '0});
    rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_ADVANCE, 16'h0, 16'h0, 12'd0, 1'b0, 32'h0),
                               0, 1'b0, '0});
    rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_START, 16'h7FFF, 16'h8000, 12'd4095, 1'b1,
                                      32'h0), 4, 1'b1,
                               mk_res(16'h7FFF, 16'h8FFF, 13'd0, 1'b1, 32'h0)});
    rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_ADVANCE, 16'h0, 16'h0, 12'd0, 1'b0, 32'h0),
                               4, 1'b0, '0});
    rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_ADVANCE, 16'h0, 16'h0, 12'd0, 1'b0, 32'h0),
                               4, 1'b0, '0});
    rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_START, 16'h8000, 16'h7FFF, 12'd4095, 1'b0,
                                      32'hA5A55A5A), 8, 1'b1,
                               mk_res(16'h8000, 16'h8FFE, mcr_pkg::SPAN_ONE, 1'b0,
                                      32'hA5A55A5A)});
    rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_ADVANCE, 16'h0, 16'h0, 12'd0, 1'b0, 32'h0),
                               8, 1'b0, '0});
    rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_ADVANCE, 16'h0, 16'h0, 12'd0, 1'b0, 32'h0),
                               8, 1'b0, '0});
    rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_START, 16'd100, -16'sd100, 12'd1, 1'b1,
                                      32'h12345678), 4, 1'b0, '0});
    rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_ADVANCE, 16'h0, 16'h0, 12'd0, 1'b0, 32'h0),
                               4, 1'b0, '0});
    rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_ADVANCE, 16'h0, 16'h0, 12'd0, 1'b0, 32'h0),
                               0, 1'b0, '0});
    rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_START, -16'sd5, 16'd7, 12'd0, 1'b1,
                                      32'h0F0F0F0F), 4, 1'b1,
                               mk_res(-16'sd5, 16'd7, 13'd0, 1'b1, 32'h0F0F0F0F)});
    rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_ADVANCE, 16'h0, 16'h0, 12'd0, 1'b0, 32'h0),
                               4, 1'b0, '0});
    rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_ADVANCE, 16'h0, 16'h0, 12'd0, 1'b0, 32'h0),
                               0, 1'b0, '0});
    rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_START, 16'd1000, 16'd2000, 12'd5, 1'b0,
                                      32'hFFFF0000), 8, 1'b0, '0});
    for (int i = 0; i < 5; i++)
      rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_ADVANCE, 16'h0, 16'h0, 12'd0, 1'b0,
                                        32'h0), -1, 1'b0, '0});
    rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_START, 16'h0, 16'h0, 12'd2048, 1'b1,
                                      32'h00FF00FF), 4, 1'b0, '0});
    rows.insert(rows.size(), '{mk_cmd(mcr_pkg::OP_ADVANCE, 16'h0, 16'h0, 12'd0, 1'b0, 32'h0),
                               -1, 1'b0, '0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      row = rows[i];
      row_typed = (row.n >= 0);
      row_n = row.n;
      row_chk = row.chk;
      row_first = row.first;
      send_cmd(row.c);
      row_typed = 0;
    end

    goal = items_sent;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  pop_stall = 0;  end
        1: begin send_idle = 83; pop_stall = 0;  end
        2: begin send_idle = 0;  pop_stall = 83; end
        default: begin send_idle = 15; pop_stall = 15; end
      endcase
      goal = goal + RAND_ITEMS / 4;
      while (items_sent < goal) rand_circle();
    end
    push = 1'b0;

    while (pending_px.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d commands, %0d circles run to completion", items_sent, circles_done);
    $display("checked %0d outline pixels and %0d fill spans, %0d errors",
             pixels_seen, spans_seen, errs);
    if (errs == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
